// ===== design/tlik_pkg.sv =====
// shared types, constants and helper functions for the two-link ik velocity step
`timescale 1ns / 1ps
package tlik_pkg;

    // cordic depth, capped at the size of the arctangent table
    localparam int CORDIC_STAGES = 16;
    localparam int N_STG = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

    // back end depth
    localparam int KIN_STAGES = 11;

    // angle constants, q4.28
    localparam logic signed [35:0] TWO_PI_Q28  = 36'sd1686629713;
    localparam logic signed [35:0] PI_Q28      = 36'sd843314857;
    localparam logic signed [35:0] HALF_PI_Q28 = 36'sd421657428;

    // cordic start value, q30
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // register indexes
    localparam logic [7:0] CFG_LINK_ONE = 8'd0;
    localparam logic [7:0] CFG_LINK_TWO = 8'd1;
    localparam logic [7:0] CFG_GAIN     = 8'd2;
    localparam logic [7:0] CFG_PERIOD   = 8'd3;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] angle_one_now;
        logic signed [31:0] angle_two_now;
    } t_item;

    typedef struct packed {
        logic [30:0] link_one_length;
        logic [30:0] link_two_length;
        logic [30:0] position_gain;
        logic [31:0] sample_period;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] angle_one_next;
        logic signed [31:0] angle_two_next;
        logic               saturated;
    } t_result;

    // arctangent of 2^-i in q30
    function automatic logic signed [33:0] atan_q30(input int i);
        case (i)
            0:  return 34'sd843314856;
            1:  return 34'sd497837829;
            2:  return 34'sd263043836;
            3:  return 34'sd133525158;
            4:  return 34'sd67021686;
            5:  return 34'sd33543515;
            6:  return 34'sd16775850;
            7:  return 34'sd8388437;
            8:  return 34'sd4194282;
            9:  return 34'sd2097149;
            10: return 34'sd1048575;
            11: return 34'sd524287;
            12: return 34'sd262143;
            13: return 34'sd131071;
            14: return 34'sd65535;
            15: return 34'sd32767;
            16: return 34'sd16383;
            17: return 34'sd8191;
            18: return 34'sd4095;
            19: return 34'sd2047;
            20: return 34'sd1023;
            21: return 34'sd511;
            22: return 34'sd255;
            23: return 34'sd127;
            24: return 34'sd63;
            25: return 34'sd31;
            26: return 34'sd15;
            27: return 34'sd8;
            28: return 34'sd4;
            29: return 34'sd2;
            30: return 34'sd1;
            default: return 34'sd0;
        endcase
    endfunction

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    // true when the clamp above would clip
    function automatic logic clip32(input logic signed [65:0] v);
        return (v > 66'sd2147483647) || (v < -66'sd2147483648);
    endfunction

endpackage

// ===== design/tlik_reduce.sv =====
// front end: input register, angle sum, reduction modulo two pi and quadrant fold
`timescale 1ns / 1ps
module tlik_reduce (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  tlik_pkg::t_item     i_item,
    output logic                o_valid,
    output tlik_pkg::t_item     o_item,
    output logic signed [33:0]  o_z_one,
    output logic signed [33:0]  o_z_sum,
    output logic [1:0]          o_neg
);
    import tlik_pkg::*;

    localparam logic signed [35:0] OFF [0:5] = '{
        36'sd3 * TWO_PI_Q28, 36'sd2 * TWO_PI_Q28, TWO_PI_Q28,
        36'sd0, -TWO_PI_Q28, -36'sd2 * TWO_PI_Q28
    };

    logic [2:0]         r_v;
    t_item              r_it [0:2];
    logic signed [35:0] r_a [0:1];
    logic signed [35:0] r_r [0:1];
    logic signed [35:0] n_r [0:1];
    logic signed [35:0] c_cand [0:1][0:5];
    logic signed [35:0] n_h [0:1];
    logic signed [35:0] n_f [0:1];
    logic [1:0]         n_neg;
    logic signed [33:0] r_z [0:1];
    logic [1:0]         r_neg;

    // pick the multiple of two pi that lands in [0, two pi)
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_r[l] = '0;
            for (int k = 0; k < 6; k++) begin
                c_cand[l][k] = r_a[l] + OFF[k];
                if (c_cand[l][k] >= 0 && c_cand[l][k] < TWO_PI_Q28) begin
                    n_r[l] = c_cand[l][k];
                end
            end
        end
    end

    // move to (-pi, pi] then fold into [-pi/2, pi/2]
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_h[l] = (r_r[l] > PI_Q28) ? r_r[l] - TWO_PI_Q28 : r_r[l];
            n_neg[l] = 1'b0;
            n_f[l] = n_h[l];
            if (n_h[l] > HALF_PI_Q28) begin
                n_f[l] = n_h[l] - PI_Q28;
                n_neg[l] = 1'b1;
            end else if (n_h[l] < -HALF_PI_Q28) begin
                n_f[l] = n_h[l] + PI_Q28;
                n_neg[l] = 1'b1;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[0] <= i_item;
            r_a[0]  <= 36'(i_item.angle_one_now);
            r_a[1]  <= 36'(i_item.angle_one_now) + 36'(i_item.angle_two_now);
            r_it[1] <= r_it[0];
            r_r[0]  <= n_r[0];
            r_r[1]  <= n_r[1];
            r_it[2] <= r_it[1];
            r_z[0]  <= 34'(n_f[0]) <<< 2;
            r_z[1]  <= 34'(n_f[1]) <<< 2;
            r_neg   <= n_neg;
        end
    end

    assign o_valid = r_v[2];
    assign o_item  = r_it[2];
    assign o_z_one = r_z[0];
    assign o_z_sum = r_z[1];
    assign o_neg   = r_neg;

endmodule

// ===== design/tlik_cordic.sv =====
// two-lane pipelined cordic in rotation mode, one stage per iteration
`timescale 1ns / 1ps
module tlik_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  tlik_pkg::t_item     i_item,
    input  logic signed [33:0]  i_z_one,
    input  logic signed [33:0]  i_z_sum,
    input  logic [1:0]          i_neg,
    output logic                o_valid,
    output tlik_pkg::t_item     o_item,
    output logic signed [33:0]  o_x_one,
    output logic signed [33:0]  o_y_one,
    output logic signed [33:0]  o_x_sum,
    output logic signed [33:0]  o_y_sum,
    output logic [1:0]          o_neg
);
    import tlik_pkg::*;

    logic [N_STG:0]     r_v;
    t_item              r_it  [0:N_STG];
    logic [1:0]         r_neg [0:N_STG];
    logic signed [33:0] r_x [0:N_STG][0:1];
    logic signed [33:0] r_y [0:N_STG][0:1];
    logic signed [33:0] r_z [0:N_STG][0:1];
    logic signed [33:0] n_x [1:N_STG][0:1];
    logic signed [33:0] n_y [1:N_STG][0:1];
    logic signed [33:0] n_z [1:N_STG][0:1];

    // one micro-rotation per stage and lane
    always_comb begin
        for (int s = 0; s < N_STG; s++) begin
            for (int l = 0; l < 2; l++) begin
                if (r_z[s][l] >= 0) begin
                    n_x[s+1][l] = r_x[s][l] - (r_y[s][l] >>> s);
                    n_y[s+1][l] = r_y[s][l] + (r_x[s][l] >>> s);
                    n_z[s+1][l] = r_z[s][l] - atan_q30(s);
                end else begin
                    n_x[s+1][l] = r_x[s][l] + (r_y[s][l] >>> s);
                    n_y[s+1][l] = r_y[s][l] - (r_x[s][l] >>> s);
                    n_z[s+1][l] = r_z[s][l] + atan_q30(s);
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N_STG-1:0], i_valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[0]   <= i_item;
            r_neg[0]  <= i_neg;
            r_x[0][0] <= CORDIC_GAIN_Q30;
            r_y[0][0] <= '0;
            r_z[0][0] <= i_z_one;
            r_x[0][1] <= CORDIC_GAIN_Q30;
            r_y[0][1] <= '0;
            r_z[0][1] <= i_z_sum;
            for (int s = 1; s <= N_STG; s++) begin
                r_it[s]  <= r_it[s-1];
                r_neg[s] <= r_neg[s-1];
                for (int l = 0; l < 2; l++) begin
                    r_x[s][l] <= n_x[s][l];
                    r_y[s][l] <= n_y[s][l];
                    r_z[s][l] <= n_z[s][l];
                end
            end
        end
    end

    assign o_valid = r_v[N_STG];
    assign o_item  = r_it[N_STG];
    assign o_neg   = r_neg[N_STG];
    assign o_x_one = r_x[N_STG][0];
    assign o_y_one = r_y[N_STG][0];
    assign o_x_sum = r_x[N_STG][1];
    assign o_y_sum = r_y[N_STG][1];

endmodule

// ===== design/tlik_kin.sv =====
// back end: link terms, tip error, commanded velocity, jacobian transpose, integration
`timescale 1ns / 1ps
module tlik_kin (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  tlik_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  tlik_pkg::t_item     i_item,
    input  logic signed [33:0]  i_x_one,
    input  logic signed [33:0]  i_y_one,
    input  logic signed [33:0]  i_x_sum,
    input  logic signed [33:0]  i_y_sum,
    input  logic [1:0]          i_neg,
    output logic                o_valid,
    output tlik_pkg::t_result   o_result
);
    import tlik_pkg::*;

    typedef struct packed {
        logic signed [32:0] jxx;
        logic signed [32:0] jxy;
        logic signed [31:0] jyx;
        logic signed [31:0] jyy;
    } t_jac;

    logic [KIN_STAGES:1] r_v;
    t_item               r_it [1:KIN_STAGES];

    logic signed [31:0] r_c1, r_s1, r_c12, r_s12;
    logic signed [63:0] r_pl1c, r_pl1s, r_pl2c, r_pl2s;
    logic signed [31:0] n_l1c, n_l1s, n_l2c, n_l2s;
    logic signed [31:0] r_px, r_py, r_l2c, r_l2s;
    logic signed [31:0] r_ex, r_ey;
    t_jac               r_jac [4:6];
    logic signed [63:0] r_pgx, r_pgy;
    logic signed [31:0] r_vx, r_vy;
    logic signed [65:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [63:0] r_w1, r_w2;
    logic [63:0]        r_m1, r_m2;
    logic [1:0]         r_sg [9:10];
    logic [63:0]        r_hp1, r_lp1, r_hp2, r_lp2;
    logic [63:0]        n_r1, n_r2;
    logic signed [65:0] n_s1, n_s2;
    logic signed [65:0] n_a1, n_a2;
    t_result            r_res;

    // link terms from the registered products
    always_comb begin
        n_l1c = sat32(66'(r_pl1c >>> 30));
        n_l1s = sat32(66'(r_pl1s >>> 30));
        n_l2c = sat32(66'(r_pl2c >>> 30));
        n_l2s = sat32(66'(r_pl2s >>> 30));
    end

    // scaled increments and new angles
    always_comb begin
        n_r1 = r_hp1 + (r_lp1 >> 32);
        n_r2 = r_hp2 + (r_lp2 >> 32);
        n_s1 = r_sg[10][0] ? -$signed(66'(n_r1)) : $signed(66'(n_r1));
        n_s2 = r_sg[10][1] ? -$signed(66'(n_r2)) : $signed(66'(n_r2));
        n_a1 = 66'(r_it[10].angle_one_now) + n_s1;
        n_a2 = 66'(r_it[10].angle_two_now) + n_s2;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[KIN_STAGES-1:1], i_valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // undo the quadrant fold
            r_it[1] <= i_item;
            r_c1    <= i_neg[0] ? 32'(-i_x_one) : 32'(i_x_one);
            r_s1    <= i_neg[0] ? 32'(-i_y_one) : 32'(i_y_one);
            r_c12   <= i_neg[1] ? 32'(-i_x_sum) : 32'(i_x_sum);
            r_s12   <= i_neg[1] ? 32'(-i_y_sum) : 32'(i_y_sum);
            // link length times trig
            r_it[2] <= r_it[1];
            r_pl1c  <= 64'($signed({1'b0, i_cfg.link_one_length})) * 64'(r_c1);
            r_pl1s  <= 64'($signed({1'b0, i_cfg.link_one_length})) * 64'(r_s1);
            r_pl2c  <= 64'($signed({1'b0, i_cfg.link_two_length})) * 64'(r_c12);
            r_pl2s  <= 64'($signed({1'b0, i_cfg.link_two_length})) * 64'(r_s12);
            // tip position
            r_it[3] <= r_it[2];
            r_px    <= sat32(66'(n_l1c) + 66'(n_l2c));
            r_py    <= sat32(66'(n_l1s) + 66'(n_l2s));
            r_l2c   <= n_l2c;
            r_l2s   <= n_l2s;
            // position error and jacobian
            r_it[4]    <= r_it[3];
            r_ex       <= sat32(66'(r_it[3].target_x) - 66'(r_px));
            r_ey       <= sat32(66'(r_it[3].target_y) - 66'(r_py));
            r_jac[4]   <= '{jxx: 33'sd0 - 33'(r_py), jxy: 33'sd0 - 33'(r_l2s),
                            jyx: r_px, jyy: r_l2c};
            // error times gain
            r_it[5]  <= r_it[4];
            r_jac[5] <= r_jac[4];
            r_pgx    <= 64'(r_ex) * 64'($signed({1'b0, i_cfg.position_gain}));
            r_pgy    <= 64'(r_ey) * 64'($signed({1'b0, i_cfg.position_gain}));
            // commanded velocity
            r_it[6]  <= r_it[5];
            r_jac[6] <= r_jac[5];
            r_vx     <= sat32(66'(r_pgx >>> 16) + 66'(r_it[5].velocity_x));
            r_vy     <= sat32(66'(r_pgy >>> 16) + 66'(r_it[5].velocity_y));
            // jacobian transpose products
            r_it[7] <= r_it[6];
            r_p1    <= 66'(r_jac[6].jxx) * 66'(r_vx);
            r_p2    <= 66'(r_jac[6].jyx) * 66'(r_vy);
            r_p3    <= 66'(r_jac[6].jxy) * 66'(r_vx);
            r_p4    <= 66'(r_jac[6].jyy) * 66'(r_vy);
            // joint rates, q28
            r_it[8] <= r_it[7];
            r_w1    <= 64'(r_p1 >>> 4) + 64'(r_p2 >>> 4);
            r_w2    <= 64'(r_p3 >>> 4) + 64'(r_p4 >>> 4);
            // magnitude and sign
            r_it[9]  <= r_it[8];
            r_m1     <= r_w1[63] ? 64'(-r_w1) : 64'(r_w1);
            r_m2     <= r_w2[63] ? 64'(-r_w2) : 64'(r_w2);
            r_sg[9]  <= {r_w2[63], r_w1[63]};
            // magnitude times period, split in halves
            r_it[10] <= r_it[9];
            r_sg[10] <= r_sg[9];
            r_hp1    <= 64'(r_m1[63:32]) * 64'(i_cfg.sample_period);
            r_lp1    <= 64'(r_m1[31:0]) * 64'(i_cfg.sample_period);
            r_hp2    <= 64'(r_m2[63:32]) * 64'(i_cfg.sample_period);
            r_lp2    <= 64'(r_m2[31:0]) * 64'(i_cfg.sample_period);
            // integrate and clamp
            r_it[11]             <= r_it[10];
            r_res.angle_one_next <= sat32(n_a1);
            r_res.angle_two_next <= sat32(n_a2);
            r_res.saturated      <= clip32(n_a1) | clip32(n_a2);
        end
    end

    assign o_valid  = r_v[KIN_STAGES];
    assign o_result = r_res;

endmodule

// ===== design/two_link_ik_velocity_step.sv =====
// two-link arm jacobian-transpose velocity step, top level with config and output skid
// an accepted input beat passes through 3 front-end stages, CORDIC_STAGES+1 cordic stages,
// 11 back-end stages and the output register before its result beat reaches the output
// throughput: one beat per cycle; a stalled output fills a one-beat skid, then holds input
// reset: synchronous active low, clears all valid bits, loads the register reset values
`timescale 1ns / 1ps
module two_link_ik_velocity_step (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // target_x, target_y, velocity_x, velocity_y, angle_one_now, angle_two_now
    input  logic [191:0] s_axis_tdata,
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // angle_one_next, angle_two_next, saturated, zero fill
    output logic [71:0]  m_axis_tdata
);
    import tlik_pkg::*;

    t_cfg               r_cfg;
    t_item              w_item;
    logic               w_en;
    logic               w_red_valid, w_cor_valid, w_kin_valid;
    t_item              w_red_item, w_cor_item;
    logic signed [33:0] w_z_one, w_z_sum;
    logic [1:0]         w_red_neg, w_cor_neg;
    logic signed [33:0] w_x_one, w_y_one, w_x_sum, w_y_sum;
    t_result            w_kin_res;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;
    logic               r_skid_valid, n_skid_valid;
    t_result            r_skid, n_skid;
    logic               w_take;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_one_length <= 31'd65536;
            r_cfg.link_two_length <= 31'd65536;
            r_cfg.position_gain   <= 31'd65536;
            r_cfg.sample_period   <= 32'd4294967;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINK_ONE: r_cfg.link_one_length <= i_cfg_data[30:0];
                CFG_LINK_TWO: r_cfg.link_two_length <= i_cfg_data[30:0];
                CFG_GAIN:     r_cfg.position_gain   <= i_cfg_data[30:0];
                CFG_PERIOD:   r_cfg.sample_period   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // unpack the input beat
    assign w_item.target_x      = s_axis_tdata[31:0];
    assign w_item.target_y      = s_axis_tdata[63:32];
    assign w_item.velocity_x    = s_axis_tdata[95:64];
    assign w_item.velocity_y    = s_axis_tdata[127:96];
    assign w_item.angle_one_now = s_axis_tdata[159:128];
    assign w_item.angle_two_now = s_axis_tdata[191:160];

    // pipeline advances while the skid is empty
    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    tlik_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_item  (w_item),
        .o_valid (w_red_valid),
        .o_item  (w_red_item),
        .o_z_one (w_z_one),
        .o_z_sum (w_z_sum),
        .o_neg   (w_red_neg)
    );

    tlik_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_red_valid),
        .i_item  (w_red_item),
        .i_z_one (w_z_one),
        .i_z_sum (w_z_sum),
        .i_neg   (w_red_neg),
        .o_valid (w_cor_valid),
        .o_item  (w_cor_item),
        .o_x_one (w_x_one),
        .o_y_one (w_y_one),
        .o_x_sum (w_x_sum),
        .o_y_sum (w_y_sum),
        .o_neg   (w_cor_neg)
    );

    tlik_kin u_kin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_cfg    (r_cfg),
        .i_valid  (w_cor_valid),
        .i_item   (w_cor_item),
        .i_x_one  (w_x_one),
        .i_y_one  (w_y_one),
        .i_x_sum  (w_x_sum),
        .i_y_sum  (w_y_sum),
        .i_neg    (w_cor_neg),
        .o_valid  (w_kin_valid),
        .o_result (w_kin_res)
    );

    // output register and skid
    assign w_take = r_out_valid && m_axis_tready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_take || !r_out_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (w_kin_valid) begin
            if (w_take || !r_out_valid) begin
                n_out       = w_kin_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_kin_res;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.saturated, r_out.angle_two_next,
                            r_out.angle_one_next};

endmodule
